FILE: rtl/rnsfc_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rnsfc_pkg
// Shared widths, register indexes and the job record for the residue
// number system forward converter.
// ----------------------------------------------------------------------------
package rnsfc_pkg;

  localparam int OPD_W     = 64;  // operand width
  localparam int MOD_W     = 31;  // modulus register width
  localparam int RES_W     = 32;  // signed residue width
  localparam int IDX_W     = 2;   // modulus index width
  localparam int CNT_W     = 3;   // moduli_in_use width
  localparam int CFG_IDX_W = 3;   // configuration register index width
  localparam int NUM_MOD   = 4;   // modulus registers a to d

  localparam int MAX_MODULI_DEF     = 4;
  localparam int STEPS_PER_CELL_DEF = 2;

  localparam logic [CFG_IDX_W-1:0] REG_MODULI_IN_USE = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_MODULUS_A     = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_MODULUS_B     = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_MODULUS_C     = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_MODULUS_D     = 3'd4;

  localparam logic [CNT_W-1:0] RST_MODULI_IN_USE = 3'd4;
  localparam logic [MOD_W-1:0] RST_MODULUS_A     = 31'd3;
  localparam logic [MOD_W-1:0] RST_MODULUS_B     = 31'd5;
  localparam logic [MOD_W-1:0] RST_MODULUS_C     = 31'd7;
  localparam logic [MOD_W-1:0] RST_MODULUS_D     = 31'd11;

  localparam logic MODE_FORWARD = 1'b0;
  localparam logic MODE_REDUCE  = 1'b1;

  typedef logic [MOD_W-1:0] mod_t;

  // One residue job travelling down the cell chain.
  typedef struct packed {
    logic [OPD_W-1:0] dvd;      // magnitude bits not yet consumed, MSB first
    mod_t             modulus;
    mod_t             rem;      // partial remainder
    logic [IDX_W-1:0] idx;
    logic             neg;      // operand was negative
    logic             last;
    logic             bad;      // index not in use
    logic             zero;     // force residue to zero
  } job_t;

endpackage

FILE: rtl/rns_forward_conversion.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rns_forward_conversion
// Signed 64-bit to residue number system converter over up to four moduli,
// with a single-modulus reduce mode.
// ----------------------------------------------------------------------------
//
//  channel  dir  handshake            payload
//  in_      in   in_tvalid/in_tready  tdata {select_index, operand}, tuser mode
//  out_     out  out_tvalid/out_tready tdata {residue, residue_index},
//                                     tlast last, tuser bad_index
//  cfg_     in   cfg_valid/cfg_ready  cfg_index, cfg_data (always ready)
//
//  Rate: one result leaves per cycle unless out_tready is held low; a forward
//  item issues one job per modulus in use (up to four), a reduce item one.
//  That rate is set by the single result port. The first result of an item
//  passes the item register, remainder chain and output stage in turn.
//  Reset: synchronous, active low; restores the moduli 3, 5, 7, 11 and count 4.
//  Stalls: a held result freezes the whole chain and the item register; a new
//  item is taken in the cycle the previous one issues its last job.
// ----------------------------------------------------------------------------
module rns_forward_conversion
  import rnsfc_pkg::*;
#(
  parameter int MAX_MODULI     = MAX_MODULI_DEF,
  parameter int STEPS_PER_CELL = STEPS_PER_CELL_DEF
) (
  input  logic                 clk,
  input  logic                 rst_n,
  // input items
  input  logic                 in_tvalid,
  output logic                 in_tready,
  input  logic [71:0]          in_tdata,   // [63:0] operand, [65:64] select_index, rest 0
  input  logic                 in_tuser,   // [0] mode
  // result items
  output logic                 out_tvalid,
  input  logic                 out_tready,
  output logic [39:0]          out_tdata,  // [1:0] residue_index, [33:2] residue, rest 0
  output logic                 out_tlast,  // last
  output logic                 out_tuser,  // [0] bad_index
  // configuration writes
  input  logic                 cfg_valid,
  output logic                 cfg_ready,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [MOD_W-1:0]     cfg_data
);

  localparam int NUM_CELLS = OPD_W / STEPS_PER_CELL;

  // --------------------------------------------------------------------------
  // Configuration registers
  // --------------------------------------------------------------------------
  logic [CNT_W-1:0] moduli_in_use_r;
  mod_t             moduli_r [NUM_MOD];

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      moduli_in_use_r <= RST_MODULI_IN_USE;
      moduli_r[0]     <= RST_MODULUS_A;
      moduli_r[1]     <= RST_MODULUS_B;
      moduli_r[2]     <= RST_MODULUS_C;
      moduli_r[3]     <= RST_MODULUS_D;
    end else if (cfg_valid) begin
      // Drop writes to indexes beyond the register list.
      unique case (cfg_index)
        REG_MODULI_IN_USE: moduli_in_use_r <= cfg_data[CNT_W-1:0];
        REG_MODULUS_A:     moduli_r[0]     <= cfg_data;
        REG_MODULUS_B:     moduli_r[1]     <= cfg_data;
        REG_MODULUS_C:     moduli_r[2]     <= cfg_data;
        REG_MODULUS_D:     moduli_r[3]     <= cfg_data;
        default: ;
      endcase
    end
  end

  // --------------------------------------------------------------------------
  // Global advance: the chain moves whenever the output stage can load.
  // --------------------------------------------------------------------------
  logic out_valid_r;
  logic adv;

  assign adv = !out_valid_r || out_tready;

  // --------------------------------------------------------------------------
  // Item register and job issue
  // --------------------------------------------------------------------------
  logic valid_c [NUM_CELLS+1];
  job_t job_c   [NUM_CELLS+1];

  rnsfc_feed #(
    .MAX_MODULI (MAX_MODULI)
  ) u_feed (
    .clk           (clk),
    .rst_n         (rst_n),
    .adv           (adv),
    .in_valid      (in_tvalid),
    .in_ready      (in_tready),
    .in_mode       (in_tuser),
    .in_operand    (in_tdata[OPD_W-1:0]),
    .in_sel        (in_tdata[OPD_W+IDX_W-1:OPD_W]),
    .moduli_in_use (moduli_in_use_r),
    .moduli        (moduli_r),
    .job_valid     (valid_c[0]),
    .job           (job_c[0])
  );

  // --------------------------------------------------------------------------
  // Remainder chain: each cell consumes STEPS_PER_CELL magnitude bits.
  // --------------------------------------------------------------------------
  for (genvar g = 0; g < NUM_CELLS; g++) begin : g_cell
    rnsfc_cell #(
      .STEPS (STEPS_PER_CELL)
    ) u_cell (
      .clk         (clk),
      .rst_n       (rst_n),
      .adv         (adv),
      .in_valid    (valid_c[g]),
      .in_job      (job_c[g]),
      .out_valid_r (valid_c[g+1]),
      .out_job_r   (job_c[g+1])
    );
  end

  // --------------------------------------------------------------------------
  // Output stage: apply the operand sign, or force zero.
  // --------------------------------------------------------------------------
  job_t             tail;
  logic [RES_W-1:0] res_mag;
  logic [RES_W-1:0] res_nxt;
  logic [IDX_W-1:0] out_idx_r;
  logic [RES_W-1:0] out_res_r;
  logic             out_last_r;
  logic             out_bad_r;

  assign tail    = job_c[NUM_CELLS];
  assign res_mag = {1'b0, tail.rem};

  always_comb begin
    priority if (tail.zero) begin
      res_nxt = '0;
    end else if (tail.neg) begin
      res_nxt = ~res_mag + RES_W'(1);
    end else begin
      res_nxt = res_mag;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (adv) begin
      out_valid_r <= valid_c[NUM_CELLS];
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      out_idx_r  <= tail.idx;
      out_res_r  <= res_nxt;
      out_last_r <= tail.last;
      out_bad_r  <= tail.bad;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {6'd0, out_res_r, out_idx_r};
  assign out_tlast  = out_last_r;
  assign out_tuser  = out_bad_r;

endmodule

FILE: rtl/rnsfc_cell.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rnsfc_cell
// One cell of the remainder chain: shift STEPS dividend bits into the partial
// remainder, subtracting the modulus where it fits, and register the job.
// ----------------------------------------------------------------------------
module rnsfc_cell
  import rnsfc_pkg::*;
#(
  parameter int STEPS = STEPS_PER_CELL_DEF
) (
  input  logic clk,
  input  logic rst_n,
  input  logic adv,
  input  logic in_valid,
  input  job_t in_job,
  output logic out_valid_r,
  output job_t out_job_r
);

  job_t job_nxt;

  always_comb begin
    job_t             j;
    logic [MOD_W:0]   t;
    j = in_job;
    t = '0;
    for (int s = 0; s < STEPS; s++) begin
      t     = {j.rem, j.dvd[OPD_W-1]};
      j.dvd = {j.dvd[OPD_W-2:0], 1'b0};
      if (t >= {1'b0, j.modulus}) begin
        t = t - {1'b0, j.modulus};
      end
      j.rem = t[MOD_W-1:0];
    end
    job_nxt = j;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (adv) begin
      out_valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      out_job_r <= job_nxt;
    end
  end

endmodule

FILE: rtl/rnsfc_feed.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rnsfc_feed
// Hold one input item and issue its residue jobs into the chain, one per
// advancing cycle, in index order.
// ----------------------------------------------------------------------------
module rnsfc_feed
  import rnsfc_pkg::*;
#(
  parameter int MAX_MODULI = MAX_MODULI_DEF
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             adv,
  input  logic             in_valid,
  output logic             in_ready,
  input  logic             in_mode,
  input  logic [OPD_W-1:0] in_operand,
  input  logic [IDX_W-1:0] in_sel,
  input  logic [CNT_W-1:0] moduli_in_use,
  input  mod_t             moduli [NUM_MOD],
  output logic             job_valid,
  output job_t             job
);

  logic             item_valid_r;
  logic             mode_r;
  logic [OPD_W-1:0] mag_r;
  logic             neg_r;
  logic [IDX_W-1:0] sel_r;
  logic [IDX_W-1:0] k_r;
  logic [IDX_W-1:0] k_nxt;

  logic [CNT_W-1:0] n_act;
  logic             fwd_empty;
  logic             fwd_last;
  logic             done;
  logic             take;
  logic [IDX_W-1:0] idx;

  // Clamp the moduli count to what the base can hold.
  assign n_act     = (moduli_in_use > CNT_W'(MAX_MODULI)) ? CNT_W'(MAX_MODULI)
                                                          : moduli_in_use;
  assign fwd_empty = (mode_r == MODE_FORWARD) && (n_act == '0);
  assign fwd_last  = ({1'b0, k_r} + CNT_W'(1)) == n_act;
  assign done      = item_valid_r &&
                     (fwd_empty || (adv && ((mode_r == MODE_REDUCE) || fwd_last)));
  assign in_ready  = !item_valid_r || done;
  assign take      = in_valid && in_ready;
  assign k_nxt     = k_r + IDX_W'(1);

  assign idx       = (mode_r == MODE_REDUCE) ? sel_r : k_r;
  assign job_valid = item_valid_r && !fwd_empty;

  always_comb begin
    job         = '0;
    job.dvd     = mag_r;
    job.modulus = moduli[idx];
    job.rem     = '0;
    job.idx     = idx;
    job.neg     = neg_r;
    if (mode_r == MODE_REDUCE) begin
      job.last = 1'b1;
      job.bad  = {1'b0, sel_r} >= n_act;
    end else begin
      job.last = fwd_last;
      job.bad  = 1'b0;
    end
    job.zero = job.bad || (moduli[idx] == '0);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      item_valid_r <= 1'b0;
      k_r          <= '0;
    end else begin
      if (take) begin
        item_valid_r <= 1'b1;
        k_r          <= '0;
      end else if (done) begin
        item_valid_r <= 1'b0;
      end else if (job_valid && adv) begin
        k_r <= k_nxt;
      end
    end
  end

  // Store the operand as sign and magnitude.
  always_ff @(posedge clk) begin
    if (take) begin
      mode_r <= in_mode;
      neg_r  <= in_operand[OPD_W-1];
      mag_r  <= in_operand[OPD_W-1] ? (~in_operand + OPD_W'(1)) : in_operand;
      sel_r  <= in_sel;
    end
  end

endmodule

FILE: dv/tb_rns_forward_conversion.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_rns_forward_conversion
// Self-checking bench for the residue converter. A clocked driver feeds
// operands from a queue and a clocked monitor predicts every residue from a
// shadow copy of the moduli registers and checks each result item in order.
// The run walks through directed corner cases, then random bases and operands
// under random idling on both sides, a long output hold-off and a drain pause.
// ----------------------------------------------------------------------------
module tb_rns_forward_conversion
  import rnsfc_pkg::*;
();

  localparam int HALF_PERIOD = 4;
  localparam int RESET_CYCLES = 5;
  // accept to first result: item register, remainder chain, output stage
  localparam int PIPE_LAT = OPD_W / STEPS_PER_CELL_DEF + 2;
  localparam int SETTLE_CYCLES = 2 * PIPE_LAT;
  localparam int LONG_HOLD = 300;
  localparam int CYCLE_LIMIT = 200000;
  localparam int RAND_PHASES = 6;
  localparam int RAND_ITEMS = 36;

  localparam logic [OPD_W-1:0] OPD_MAX = {1'b0, {(OPD_W-1){1'b1}}};
  localparam logic [OPD_W-1:0] OPD_MIN = {1'b1, {(OPD_W-1){1'b0}}};
  localparam mod_t MOD_MAX = '1;

  typedef struct {
    logic             mode;
    logic [OPD_W-1:0] operand;
    logic [IDX_W-1:0] sel;
  } conv_item_t;

  typedef struct {
    logic [IDX_W-1:0] idx;
    logic [RES_W-1:0] residue;
    logic             last;
    logic             bad;
  } residue_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;

  logic                 in_tvalid = 1'b0;
  logic                 in_tready;
  logic [71:0]          in_tdata = '0;  // [63:0] operand, [65:64] select_index
  logic                 in_tuser = 1'b0; // [0] mode
  logic                 out_tvalid;
  logic                 out_tready = 1'b0;
  logic [39:0]          out_tdata;      // [1:0] residue_index, [33:2] residue
  logic                 out_tlast;      // last
  logic                 out_tuser;      // [0] bad_index
  logic                 cfg_valid = 1'b0;
  logic                 cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [MOD_W-1:0]     cfg_data = '0;

  // Stimulus and scoreboard state
  conv_item_t operand_q[$];
  residue_t   residue_q[$];
  conv_item_t next_item;
  conv_item_t seen_item;
  residue_t   want;

  int   queued_cnt = 0;
  int   accepted_cnt = 0;
  int   err_cnt = 0;
  int   cycle_cnt = 0;
  int   in_gap = 0;
  int   out_gap = 0;
  int   out_wait = 0;
  int   hold_left = 0;
  int   hold_req = 0;
  int   hold_ack = 0;
  logic in_acc = 1'b0;
  logic out_acc = 1'b0;
  logic in_pause = 1'b0;
  logic sender_calm = 1'b0;
  logic receiver_calm = 1'b0;

  // Shadow copy of the configuration registers
  logic [CNT_W-1:0] base_count;
  mod_t             base_mod[NUM_MOD];

  rns_forward_conversion uut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast),
    .out_tuser  (out_tuser),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data)
  );

  always #HALF_PERIOD clk = ~clk;

  // --------------------------------------------------------------------------
  // Prediction
  // --------------------------------------------------------------------------

  // Truncating remainder: reduce the magnitude, then give it back the sign of
  // the operand. A zero modulus yields zero.
  function automatic logic [RES_W-1:0] trunc_residue(logic [OPD_W-1:0] opd, mod_t m);
    logic [OPD_W-1:0] mag;
    logic [OPD_W-1:0] rem;
    if (m == '0) return '0;
    mag = opd[OPD_W-1] ? -opd : opd;
    rem = mag % {{(OPD_W-MOD_W){1'b0}}, m};
    if (opd[OPD_W-1]) rem = -rem;
    return rem[RES_W-1:0];
  endfunction

  // Append the residues that one accepted item is bound to produce.
  task automatic predict_residues(conv_item_t it);
    int       n;
    residue_t r;
    // a count past the hardware limit clamps to the limit
    n = (int'(base_count) > MAX_MODULI_DEF) ? MAX_MODULI_DEF : int'(base_count);
    if (it.mode == MODE_FORWARD) begin
      // an empty base produces nothing at all
      for (int i = 0; i < n; i++) begin
        r.idx     = IDX_W'(i);
        r.residue = trunc_residue(it.operand, base_mod[i]);
        r.last    = (i + 1 == n);
        r.bad     = 1'b0;
        residue_q = {residue_q, r};
      end
    end else begin
      r.idx  = it.sel;
      r.last = 1'b1;
      // an index outside the base is flagged and reads as zero
      r.bad     = (int'(it.sel) >= n);
      r.residue = r.bad ? '0 : trunc_residue(it.operand, base_mod[it.sel]);
      residue_q = {residue_q, r};
    end
  endtask

  // --------------------------------------------------------------------------
  // Monitor: sample every handshake at the rising edge
  // --------------------------------------------------------------------------
  always @(posedge clk) begin
    in_acc  <= rst_n && in_tvalid && in_tready;
    out_acc <= rst_n && out_tvalid && out_tready;
    if (!rst_n) begin
      base_count  = RST_MODULI_IN_USE;
      base_mod[0] = RST_MODULUS_A;
      base_mod[1] = RST_MODULUS_B;
      base_mod[2] = RST_MODULUS_C;
      base_mod[3] = RST_MODULUS_D;
    end else begin
      // track register writes in the shadow copy
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          REG_MODULI_IN_USE: base_count  = cfg_data[CNT_W-1:0];
          REG_MODULUS_A:     base_mod[0] = cfg_data;
          REG_MODULUS_B:     base_mod[1] = cfg_data;
          REG_MODULUS_C:     base_mod[2] = cfg_data;
          REG_MODULUS_D:     base_mod[3] = cfg_data;
          default: ;
        endcase
      end
      if (in_tvalid && in_tready) begin
        seen_item.operand = in_tdata[OPD_W-1:0];
        seen_item.sel     = in_tdata[OPD_W+IDX_W-1:OPD_W];
        seen_item.mode    = in_tuser;
        predict_residues(seen_item);
        accepted_cnt <= accepted_cnt + 1;
      end
      if (out_tvalid && out_tready) begin
        if (residue_q.size() == 0) begin
          $display("%0t: result with nothing expected: index %0d residue %0d last %0b bad %0b",
                   $time, out_tdata[1:0], $signed(out_tdata[33:2]), out_tlast, out_tuser);
          err_cnt++;
        end else begin
          want = residue_q.pop_front();
          if (out_tdata[1:0] !== want.idx) begin
            $display("%0t: residue_index expected %0d actual %0d",
                     $time, want.idx, out_tdata[1:0]);
            err_cnt++;
          end
          if (out_tdata[33:2] !== want.residue) begin
            $display("%0t: residue (index %0d) expected %0d actual %0d", $time, want.idx,
                     $signed(want.residue), $signed(out_tdata[33:2]));
            err_cnt++;
          end
          if (out_tlast !== want.last) begin
            $display("%0t: last (index %0d) expected %0b actual %0b",
                     $time, want.idx, want.last, out_tlast);
            err_cnt++;
          end
          if (out_tuser !== want.bad) begin
            $display("%0t: bad_index (index %0d) expected %0b actual %0b",
                     $time, want.idx, want.bad, out_tuser);
            err_cnt++;
          end
        end
      end
    end
  end

  // Watchdog: end a hung run.
  always @(posedge clk) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt >= CYCLE_LIMIT) begin
      $display("** rns_forward_conversion: FAILED **");
      $finish;
    end
  end

  // --------------------------------------------------------------------------
  // Driver: present queued operands at the falling edge
  // --------------------------------------------------------------------------
  always @(negedge clk) begin
    if (!rst_n) begin
      in_tvalid <= 1'b0;
    end else if (!in_tvalid || in_acc) begin
      // slot is free: idle out the drawn gap, then offer the next item
      if (in_gap > 0) begin
        in_tvalid <= 1'b0;
        in_gap    <= in_gap - 1;
      end else if (operand_q.size() != 0 && !in_pause) begin
        next_item = operand_q.pop_front();
        in_tdata  <= {{(72-OPD_W-IDX_W){1'b0}}, next_item.sel, next_item.operand};
        in_tuser  <= next_item.mode;
        in_tvalid <= 1'b1;
        in_gap    <= sender_calm ? 0 : $urandom_range(0, 12);
      end else begin
        in_tvalid <= 1'b0;
      end
    end
  end

  // Long output hold-off, counted here and started on request.
  always @(negedge clk) begin
    if (hold_ack != hold_req) begin
      hold_ack  <= hold_req;
      hold_left <= LONG_HOLD;
    end else if (hold_left > 0) begin
      hold_left <= hold_left - 1;
    end
  end

  // Receiver: after each taken result, drop ready for a drawn number of cycles.
  always @(negedge clk) begin
    if (!rst_n) begin
      out_tready <= 1'b0;
      out_gap    <= 0;
    end else if (hold_left > 0) begin
      out_tready <= 1'b0;
    end else if (out_gap > 0) begin
      out_tready <= 1'b0;
      out_gap    <= out_gap - 1;
    end else if (out_acc) begin
      out_wait = receiver_calm ? 0 : $urandom_range(0, 12);
      out_tready <= (out_wait == 0);
      out_gap    <= (out_wait == 0) ? 0 : out_wait - 1;
    end else begin
      out_tready <= 1'b1;
    end
  end

  // --------------------------------------------------------------------------
  // Stimulus
  // --------------------------------------------------------------------------

  // Queue one operand; call only at a rising edge so the driver sees it cleanly.
  task automatic queue_operand(logic mode, logic [OPD_W-1:0] opd, logic [IDX_W-1:0] sel);
    conv_item_t it;
    it.mode    = mode;
    it.operand = opd;
    it.sel     = sel;
    operand_q  = {operand_q, it};
    queued_cnt++;
  endtask

  // Hold until every queued item is taken and every residue has come back.
  task automatic wait_drained();
    @(negedge clk);
    while (accepted_cnt != queued_cnt || residue_q.size() != 0) @(negedge clk);
  endtask

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [MOD_W-1:0] val);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
  endtask

  // Load a new base while the block is idle; returns on a rising edge.
  task automatic set_base(logic [CNT_W-1:0] cnt, mod_t ma, mod_t mb, mod_t mc, mod_t md);
    wait_drained();
    // a forward item over an empty base gives no result, so let the chain empty
    repeat (SETTLE_CYCLES) @(negedge clk);
    write_reg(REG_MODULI_IN_USE, MOD_W'(cnt));
    write_reg(REG_MODULUS_A, ma);
    write_reg(REG_MODULUS_B, mb);
    write_reg(REG_MODULUS_C, mc);
    write_reg(REG_MODULUS_D, md);
    @(negedge clk);
    cfg_valid <= 1'b0;
    @(posedge clk);
  endtask

  function automatic logic [OPD_W-1:0] rand_operand();
    logic [OPD_W-1:0] v;
    v = {$urandom, $urandom};
    case ($urandom_range(0, 7))
      0: v = OPD_W'(longint'($urandom_range(0, 2000)) - 1000);
      1: v = v[0] ? OPD_MIN : OPD_MAX;
      2: v = {v[OPD_W-1], {(OPD_W-14){~v[OPD_W-1]}}, v[12:0]};  // near the extremes
      3: v = {{(OPD_W-32){v[OPD_W-1]}}, v[31:0]};
      default: ;
    endcase
    return v;
  endfunction

  function automatic mod_t rand_modulus();
    case ($urandom_range(0, 11))
      0: return '0;
      1: return MOD_MAX;
      2: return MOD_W'(1);
      3, 4, 5: return MOD_W'($urandom_range(2, 40));
      default: return MOD_W'($urandom);
    endcase
  endfunction

  function automatic logic [CNT_W-1:0] rand_count();
    case ($urandom_range(0, 9))
      0: return '0;
      1: return CNT_W'($urandom_range(5, 7));
      default: return CNT_W'($urandom_range(1, 4));
    endcase
  endfunction

  // One random phase. long_hold stalls the receiver while the sender streams
  // flat out; mid_pause stops the sender halfway until all results are in.
  task automatic rand_phase(int n, bit long_hold, bit mid_pause);
    int start_cnt;
    start_cnt = queued_cnt;
    sender_calm   <= long_hold ? 1'b1 : ($urandom_range(0, 3) == 0);
    receiver_calm <= ($urandom_range(0, 3) == 0);
    if (long_hold) hold_req <= hold_req + 1;
    for (int i = 0; i < n; i++) begin
      queue_operand($urandom_range(0, 1) ? MODE_REDUCE : MODE_FORWARD, rand_operand(),
                    IDX_W'($urandom_range(0, 3)));
    end
    if (mid_pause) begin
      @(negedge clk);
      while (accepted_cnt < start_cnt + n / 2) @(negedge clk);
      in_pause <= 1'b1;
      @(negedge clk);
      while (in_tvalid || residue_q.size() != 0) @(negedge clk);
      in_pause <= 1'b0;
    end
  endtask

  initial begin
    repeat (RESET_CYCLES) @(negedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Reset base 3, 5, 7, 11: zero, unit and extreme operands, every index
    queue_operand(MODE_FORWARD, '0, '0);
    queue_operand(MODE_FORWARD, OPD_W'(1), '0);
    queue_operand(MODE_FORWARD, '1, 2'd3);
    queue_operand(MODE_FORWARD, OPD_MAX, '0);
    queue_operand(MODE_FORWARD, OPD_MIN, '0);
    for (int s = 0; s < NUM_MOD; s++) begin
      queue_operand(MODE_REDUCE, -OPD_W'(100), IDX_W'(s));
    end
    queue_operand(MODE_REDUCE, OPD_MIN, 2'd3);

    // Two moduli, largest and unit modulus; upper indexes are out of the base
    set_base(3'd2, MOD_MAX, MOD_W'(1), '0, MOD_MAX - 1);
    queue_operand(MODE_FORWARD, OPD_MIN, '0);
    queue_operand(MODE_FORWARD, OPD_MAX, 2'd1);
    queue_operand(MODE_REDUCE, -OPD_W'(7), 2'd1);
    queue_operand(MODE_REDUCE, OPD_MAX, 2'd2);
    queue_operand(MODE_REDUCE, OPD_MIN, 2'd3);
    queue_operand(MODE_REDUCE, OPD_W'(12345), 2'd0);

    // Empty base: forward gives nothing, reduce is always flagged
    set_base('0, MOD_W'(13), MOD_W'(17), MOD_W'(19), MOD_W'(23));
    queue_operand(MODE_FORWARD, OPD_W'(99), '0);
    queue_operand(MODE_REDUCE, -OPD_W'(5), '0);

    // Count above the limit, plus a zero modulus in the base
    set_base('1, MOD_W'(2), MOD_MAX, '0, MOD_W'(1));
    queue_operand(MODE_FORWARD, -OPD_W'(123456789), '0);
    queue_operand(MODE_REDUCE, OPD_W'(77), 2'd2);
    queue_operand(MODE_REDUCE, OPD_MIN, 2'd3);
    queue_operand(MODE_FORWARD, OPD_MAX, 2'd2);

    // Random bases and operands; phase 2 backs up the chain, phase 4 pauses
    for (int p = 0; p < RAND_PHASES; p++) begin
      set_base(rand_count(), rand_modulus(), rand_modulus(), rand_modulus(), rand_modulus());
      rand_phase(RAND_ITEMS, p == 2, p == 4);
    end

    wait_drained();
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (err_cnt == 0) begin
      $display("** rns_forward_conversion: PASSED **");
    end else begin
      $display("** rns_forward_conversion: FAILED **");
    end
    $finish;
  end

endmodule

FILE: rns_forward_conversion.f
rtl/rnsfc_pkg.sv
rtl/rnsfc_cell.sv
rtl/rnsfc_feed.sv
rtl/rns_forward_conversion.sv
dv/tb_rns_forward_conversion.sv
